// File: src/hca_pkg.sv
// ----------------------------------------------------------------------------
// hca_pkg
// Shared types and constants of the hit cluster accumulator.
// ----------------------------------------------------------------------------
package hca_pkg;

	localparam int DEF_MAX_HITS = 256;

	localparam logic [7:0] PLANE_INVALID = 8'd255;
	localparam logic       FUNC_INSERT   = 1'b0;
	localparam logic       FUNC_FINISH   = 1'b1;

	localparam int SWC_W  = 40;
	localparam int SWT_W  = 64;
	localparam int DIV_W  = SWT_W + 8;
	localparam int SUMW_W = 24;

	// cluster snapshot handed from the front to the back
	typedef struct packed {
		logic [7:0]        plane;
		logic [8:0]        count;
		logic [39:0]       first_time;
		logic [39:0]       last_time;
		logic [15:0]       low_coord;
		logic [15:0]       high_coord;
		logic [15:0]       earliest_coord;
		logic [15:0]       latest_coord;
		logic [SUMW_W-1:0] weight;
		logic [SWC_W-1:0]  swc;
		logic [SWT_W-1:0]  swt;
		logic [15:0]       utpc;
	} snap_t;

endpackage

// File: src/hca_hit_if.sv
// ----------------------------------------------------------------------------
// hca_hit_if
// Input channel: one hit or finish item per handshake.
// ----------------------------------------------------------------------------
interface hca_hit_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [7:0]  hit_plane;
	logic [39:0] hit_time;
	logic [15:0] hit_coord;
	logic [15:0] hit_weight;

	modport source (output valid, func, hit_plane, hit_time, hit_coord, hit_weight,
		input ready);
	modport sink (input valid, func, hit_plane, hit_time, hit_coord, hit_weight,
		output ready);
endinterface

// File: src/hca_sum_if.sv
// ----------------------------------------------------------------------------
// hca_sum_if
// Output channel: one cluster summary item per handshake.
// ----------------------------------------------------------------------------
interface hca_sum_if;
	logic        valid;
	logic        ready;
	logic [7:0]  plane_out;
	logic [8:0]  count_out;
	logic [39:0] first_time;
	logic [39:0] last_time;
	logic [15:0] low_coord;
	logic [15:0] high_coord;
	logic [15:0] earliest_coord;
	logic [15:0] latest_coord;
	logic [23:0] weight_total;
	logic [23:0] coord_centroid;
	logic [47:0] time_centroid;
	logic [15:0] utpc_coord;

	modport source (output valid, plane_out, count_out, first_time, last_time, low_coord,
		high_coord, earliest_coord, latest_coord, weight_total, coord_centroid,
		time_centroid, utpc_coord, input ready);
	modport sink (input valid, plane_out, count_out, first_time, last_time, low_coord,
		high_coord, earliest_coord, latest_coord, weight_total, coord_centroid,
		time_centroid, utpc_coord, output ready);
endinterface

// File: src/hit_cluster_accumulator_core.sv
// ----------------------------------------------------------------------------
// hit_cluster_accumulator_core
// Accumulates detector hits into one cluster and emits a summary per finish.
// ----------------------------------------------------------------------------
//  channel  dir  items
//  req      in   hit insert (func 0) or finish (func 1)
//  rsp      out  cluster summary, one per finish item
//
//  hit items are taken one per cycle unless a finish item stalls req: multiply stage then accumulate stage
//  a finish item pushes a snapshot into a two-entry queue and clears the cluster
//  the back loads each snapshot, runs 72 divider steps and outputs the summary;
//  the steps are those of the bit-serial centroid dividers; hits keep flowing meanwhile
//  reset clears the cluster to empty; no clearing pass
//  rsp stalls hold the summary; with the queue full a finish item stalls req
// ----------------------------------------------------------------------------
module hit_cluster_accumulator_core import hca_pkg::*; #(
	parameter int MAX_HITS = DEF_MAX_HITS
) (
	input  logic      clk,
	input  logic      arst_n,
	hca_hit_if.sink   req,
	hca_sum_if.source rsp
);
	snap_t push_data, pop_data;
	logic  push_valid, push_ready, pop_valid, pop_ready;

	hca_front #(.MAX_HITS(MAX_HITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	hca_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	hca_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.rsp       (rsp)
	);

endmodule

// File: src/hca_front.sv
// ----------------------------------------------------------------------------
// hca_front
// Takes hit and finish items, multiplies in one stage and accumulates the
// cluster state in the next; a finish item pushes a snapshot and clears.
// ----------------------------------------------------------------------------
module hca_front import hca_pkg::*; #(
	parameter int MAX_HITS = DEF_MAX_HITS
) (
	input  logic        clk,
	input  logic        arst_n,
	hca_hit_if.sink     req,
	output snap_t       push_data,
	output logic        push_valid,
	input  logic        push_ready
);
	localparam int CW = $clog2(MAX_HITS + 1);
	localparam int IW = $clog2(MAX_HITS);

	logic        valid_s1;
	logic        func_s1;
	logic [7:0]  plane_s1;
	logic [39:0] time_s1;
	logic [15:0] coord_s1;
	logic [15:0] weight_s1;
	logic [31:0] wc_s1;
	logic [55:0] wt_s1;

	logic [7:0]        plane_q;
	logic [CW-1:0]     cnt_q;
	logic [39:0]       tmin_q, tmax_q;
	logic [15:0]       cmin_q, cmax_q, early_q, late_q;
	logic [SUMW_W-1:0] sw_q;
	logic [SWC_W-1:0]  swc_q;
	logic [SWT_W-1:0]  swt_q;
	logic [IW-1:0]     lf_idx_q, ll_idx_q;
	logic [15:0]       lf_coord_q, lf_weight_q, ll_coord_q, ll_weight_q;

	logic          advance;
	logic          first;
	logic          room;
	logic [IW-1:0] idx;
	logic [CW-1:0] tail;
	logic [15:0]   utpc;

	assign advance    = !valid_s1 || (func_s1 == FUNC_INSERT) || push_ready;
	assign req.ready  = advance;
	assign push_valid = valid_s1 && (func_s1 == FUNC_FINISH);
	assign first      = (cnt_q == '0);
	assign room       = (cnt_q < CW'(MAX_HITS));
	assign idx        = cnt_q[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			func_s1   <= req.func;
			plane_s1  <= req.hit_plane;
			time_s1   <= req.hit_time;
			coord_s1  <= req.hit_coord;
			weight_s1 <= req.hit_weight;
			wc_s1     <= req.hit_weight * req.hit_coord;
			wt_s1     <= req.hit_weight * req.hit_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q     <= PLANE_INVALID;
			cnt_q       <= '0;
			tmin_q      <= '0;
			tmax_q      <= '0;
			cmin_q      <= '0;
			cmax_q      <= '0;
			early_q     <= '0;
			late_q      <= '0;
			sw_q        <= '0;
			swc_q       <= '0;
			swt_q       <= '0;
			lf_idx_q    <= '0;
			ll_idx_q    <= '0;
			lf_coord_q  <= '0;
			lf_weight_q <= '0;
			ll_coord_q  <= '0;
			ll_weight_q <= '0;
		end else if (valid_s1 && advance) begin
			if (func_s1 == FUNC_FINISH) begin
				plane_q     <= PLANE_INVALID;
				cnt_q       <= '0;
				tmin_q      <= '0;
				tmax_q      <= '0;
				cmin_q      <= '0;
				cmax_q      <= '0;
				early_q     <= '0;
				late_q      <= '0;
				sw_q        <= '0;
				swc_q       <= '0;
				swt_q       <= '0;
				lf_idx_q    <= '0;
				ll_idx_q    <= '0;
				lf_coord_q  <= '0;
				lf_weight_q <= '0;
				ll_coord_q  <= '0;
				ll_weight_q <= '0;
			end else if (room) begin
				cnt_q <= cnt_q + CW'(1);
				sw_q  <= sw_q + SUMW_W'(weight_s1);
				swc_q <= swc_q + SWC_W'(wc_s1);
				swt_q <= swt_q + SWT_W'(wt_s1);
				if (first) begin
					plane_q     <= plane_s1;
					tmin_q      <= time_s1;
					tmax_q      <= time_s1;
					cmin_q      <= coord_s1;
					cmax_q      <= coord_s1;
					early_q     <= coord_s1;
					late_q      <= coord_s1;
					lf_idx_q    <= '0;
					ll_idx_q    <= '0;
					lf_coord_q  <= coord_s1;
					lf_weight_q <= weight_s1;
					ll_coord_q  <= coord_s1;
					ll_weight_q <= weight_s1;
				end else begin
					if (plane_q != plane_s1) begin
						plane_q <= PLANE_INVALID;
					end
					if (time_s1 < tmin_q) begin
						tmin_q  <= time_s1;
						early_q <= coord_s1;
					end
					if (time_s1 == tmax_q) begin
						ll_idx_q    <= idx;
						ll_coord_q  <= coord_s1;
						ll_weight_q <= weight_s1;
					end else if (time_s1 > tmax_q) begin
						lf_idx_q    <= idx;
						ll_idx_q    <= idx;
						lf_coord_q  <= coord_s1;
						lf_weight_q <= weight_s1;
						ll_coord_q  <= coord_s1;
						ll_weight_q <= weight_s1;
						tmax_q      <= time_s1;
						late_q      <= coord_s1;
					end
					if (coord_s1 < cmin_q) begin
						cmin_q <= coord_s1;
					end
					if (coord_s1 > cmax_q) begin
						cmax_q <= coord_s1;
					end
				end
			end
		end
	end

	// utpc: pick the latest-time hit nearer to its end of the cluster
	always_comb begin
		tail = (cnt_q - CW'(1)) - CW'(ll_idx_q);
		if (first) begin
			utpc = '0;
		end else if (lf_idx_q == ll_idx_q) begin
			utpc = ll_coord_q;
		end else if (CW'(lf_idx_q) < tail) begin
			utpc = lf_coord_q;
		end else if (CW'(lf_idx_q) > tail) begin
			utpc = ll_coord_q;
		end else if (lf_weight_q > ll_weight_q) begin
			utpc = lf_coord_q;
		end else begin
			utpc = ll_coord_q;
		end
	end

	always_comb begin
		push_data.plane          = plane_q;
		push_data.count          = 9'(cnt_q);
		push_data.first_time     = tmin_q;
		push_data.last_time      = tmax_q;
		push_data.low_coord      = cmin_q;
		push_data.high_coord     = cmax_q;
		push_data.earliest_coord = early_q;
		push_data.latest_coord   = late_q;
		push_data.weight         = sw_q;
		push_data.swc            = swc_q;
		push_data.swt            = swt_q;
		push_data.utpc           = utpc;
	end

endmodule

// File: src/hca_queue.sv
// ----------------------------------------------------------------------------
// hca_queue
// Two-entry snapshot queue between the front and the back.
// ----------------------------------------------------------------------------
module hca_queue import hca_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  snap_t push_data,
	input  logic  push_valid,
	output logic  push_ready,
	output snap_t pop_data,
	output logic  pop_valid,
	input  logic  pop_ready
);
	snap_t      head_q, tail_q;
	logic [1:0] fill_q;
	logic       push, pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_data   = head_q;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			head_q <= (fill_q == 2'd2) ? tail_q : push_data;
		end else if (push && fill_q == 2'd0) begin
			head_q <= push_data;
		end
		if (push && ((fill_q == 2'd1 && !pop) || fill_q == 2'd2)) begin
			tail_q <= push_data;
		end
	end

endmodule

// File: src/hca_back.sv
// ----------------------------------------------------------------------------
// hca_back
// Takes a snapshot, runs both centroid divisions bit-serially side by side
// and holds the summary item until it is taken.
// ----------------------------------------------------------------------------
module hca_back import hca_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  snap_t   pop_data,
	input  logic    pop_valid,
	output logic    pop_ready,
	hca_sum_if.source rsp
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;
	localparam int         STEP_W  = $clog2(DIV_W);

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;
	snap_t             snap_q;
	logic [DIV_W-1:0]  nt_q, nc_q;
	logic [SUMW_W-1:0] rt_q, rc_q;

	logic [SUMW_W:0]   trial_t, trial_c;
	logic              ge_t, ge_c;

	assign pop_ready = (state_q == ST_IDLE);

	// one restoring step per cycle, quotient bits shift into the dividend
	always_comb begin
		trial_t = {rt_q, nt_q[DIV_W-1]};
		trial_c = {rc_q, nc_q[DIV_W-1]};
		ge_t    = trial_t >= {1'b0, snap_q.weight};
		ge_c    = trial_c >= {1'b0, snap_q.weight};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_W - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop_valid) begin
			snap_q <= pop_data;
			nt_q   <= {pop_data.swt, 8'd0};
			nc_q   <= DIV_W'({pop_data.swc, 8'd0});
			rt_q   <= '0;
			rc_q   <= '0;
		end else if (state_q == ST_DIV) begin
			rt_q <= ge_t ? SUMW_W'(trial_t - {1'b0, snap_q.weight}) : SUMW_W'(trial_t);
			rc_q <= ge_c ? SUMW_W'(trial_c - {1'b0, snap_q.weight}) : SUMW_W'(trial_c);
			nt_q <= {nt_q[DIV_W-2:0], ge_t};
			nc_q <= {nc_q[DIV_W-2:0], ge_c};
		end
	end

	assign rsp.valid          = (state_q == ST_OUT);
	assign rsp.plane_out      = snap_q.plane;
	assign rsp.count_out      = snap_q.count;
	assign rsp.first_time     = snap_q.first_time;
	assign rsp.last_time      = snap_q.last_time;
	assign rsp.low_coord      = snap_q.low_coord;
	assign rsp.high_coord     = snap_q.high_coord;
	assign rsp.earliest_coord = snap_q.earliest_coord;
	assign rsp.latest_coord   = snap_q.latest_coord;
	assign rsp.weight_total   = snap_q.weight;
	assign rsp.coord_centroid = (snap_q.weight == '0) ? 24'd0 : nc_q[23:0];
	assign rsp.time_centroid  = (snap_q.weight == '0) ? 48'd0 : nt_q[47:0];
	assign rsp.utpc_coord     = snap_q.utpc;

endmodule

// File: src/hca_checker.sv
// ----------------------------------------------------------------------------
// hca_checker
// Port-level checks on the summary channel of the accumulator.
// ----------------------------------------------------------------------------
module hca_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [7:0]  plane_out,
	input logic [8:0]  count_out,
	input logic [39:0] first_time,
	input logic [39:0] last_time,
	input logic [15:0] low_coord,
	input logic [15:0] high_coord,
	input logic [23:0] weight_total,
	input logic [23:0] coord_centroid,
	input logic [47:0] time_centroid
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(time_centroid))
		else $error("summary item changed while stalled");

	// an empty cluster reports the invalid plane and no weight
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		valid && count_out == 9'd0 |-> plane_out == 8'd255 && weight_total == 24'd0)
		else $error("empty cluster summary not cleared");

	a_zero_w: assert property (@(posedge clk) disable iff (!arst_n)
		valid && weight_total == 24'd0 |-> coord_centroid == 24'd0 && time_centroid == 48'd0)
		else $error("centroid nonzero with zero weight");

	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> first_time <= last_time && low_coord <= high_coord)
		else $error("cluster bounds out of order");

endmodule

bind hit_cluster_accumulator_core hca_checker u_hca_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.valid          (rsp.valid),
	.ready          (rsp.ready),
	.plane_out      (rsp.plane_out),
	.count_out      (rsp.count_out),
	.first_time     (rsp.first_time),
	.last_time      (rsp.last_time),
	.low_coord      (rsp.low_coord),
	.high_coord     (rsp.high_coord),
	.weight_total   (rsp.weight_total),
	.coord_centroid (rsp.coord_centroid),
	.time_centroid  (rsp.time_centroid)
);
